>>> design/top_k_sorted_insert_table_macros.svh
// assertion macros for the sorted top-k table
`ifndef TOP_K_SORTED_INSERT_TABLE_MACROS_SVH
`define TOP_K_SORTED_INSERT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define TKST_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tkst check failed");
`define TKST_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tkst check failed");
`else
`define TKST_ASSERT_SAME(lbl, pre, post)
`define TKST_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> design/tkst_pkg.sv
// shared types and constants for the sorted top-k table
package tkst_pkg;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] key_value;
    logic [TAG_W-1:0]        tag_value;
    logic [SLOT_W-1:0]       slot_index;
  } req_t;

  typedef struct packed {
    logic                    accepted;
    logic [POS_W-1:0]        position;
    logic [COUNT_W-1:0]      entry_count;
    logic signed [KEY_W-1:0] read_key;
    logic [TAG_W-1:0]        read_tag;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic execute;
  } ctrl_cmd_t;

endpackage

>>> design/tkst_channels.sv
// request and response channel interfaces
interface tkst_req_if import tkst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key_value;
  logic [TAG_W-1:0]        tag_value;
  logic [SLOT_W-1:0]       slot_index;

  modport source (output valid, command, key_value, tag_value, slot_index, input ready);
  modport sink (input valid, command, key_value, tag_value, slot_index, output ready);
endinterface

interface tkst_rsp_if import tkst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [POS_W-1:0]        position;
  logic [COUNT_W-1:0]      entry_count;
  logic signed [KEY_W-1:0] read_key;
  logic [TAG_W-1:0]        read_tag;

  modport source (output valid, accepted, position, entry_count, read_key, read_tag,
                  input ready);
  modport sink (input valid, accepted, position, entry_count, read_key, read_tag,
                output ready);
endinterface

>>> design/top_k_sorted_insert_table.sv
// top level of the sorted top-k table
// Holds up to MAX_ENTRIES (key, tag) pairs in descending signed key order.
// request channel: one beat carries command, key_value, tag_value, slot_index.
//   insert places the pair after all equal keys, shifting lower ones down;
//   on a full table the last pair drops, and a key not above it is refused.
//   read returns the pair at slot_index (zero beyond the table or if unset).
//   clear zeroes the table; any other code only reports the count.
// response channel: exactly one beat per request with accepted, position,
//   entry_count (count after the step), read_key and read_tag.
// A request is captured when taken and is executed once the output is free;
//   its response is then held in the result register.
// A new request is taken only after the previous one has executed; the capture
//   register feeds one execute step sharing the compare row and the cell row.
// Reset (synchronous, rst high) empties the table and drops any pending beat.
// When the response side stalls, the held response stays put; one further
//   request is taken and waits in the execute step until the output is free.
module top_k_sorted_insert_table import tkst_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_BITS    = 16
) (
  input logic        clk,
  input logic        rst,
  tkst_req_if.sink   request,
  tkst_rsp_if.source response
);

`include "top_k_sorted_insert_table_macros.svh"

  ctrl_cmd_t cmd;
  req_t      req;
  rsp_t      rsp;

  assign req.command    = request.command;
  assign req.key_value  = request.key_value;
  assign req.tag_value  = request.tag_value;
  assign req.slot_index = request.slot_index;

  tkst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .cmd       (cmd)
  );

  tkst_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  assign response.accepted    = rsp.accepted;
  assign response.position    = rsp.position;
  assign response.entry_count = rsp.entry_count;
  assign response.read_key    = rsp.read_key;
  assign response.read_tag    = rsp.read_tag;

  // one request in flight at a time
  `TKST_ASSERT_NEXT(a_one_in_flight, request.valid && request.ready, !request.ready)
  `TKST_ASSERT_SAME(a_count_bound, response.valid,
                    (MAX_ENTRIES > 31) || (response.entry_count <= MAX_ENTRIES))
  `TKST_ASSERT_SAME(a_pos_in_list, response.valid && response.accepted,
                    (MAX_ENTRIES > 15) || (response.position < response.entry_count))
  `TKST_ASSERT_SAME(a_insert_no_read, response.valid && response.accepted,
                    (response.read_key == 0) && (response.read_tag == 0))

endmodule

>>> design/tkst_ctrl.sv
// controller: takes a beat, runs it against the table, hands the result on
module tkst_ctrl import tkst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ctrl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state, state_next;
  logic rsp_valid_next;
  logic out_free;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd.load_req   = 1'b0;
    cmd.execute    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait here while the previous result is still held
        if (out_free) begin
          cmd.execute    = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> design/tkst_dpath.sv
// datapath: row of sorted cells, compare row, read select and result register
module tkst_dpath import tkst_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  req_t      req,
  output rsp_t      rsp
);

  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TC  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int SC  = (IW < SLOT_W) ? IW : SLOT_W;
  localparam int PC  = (CW < POS_W) ? CW : POS_W;
  localparam int NC  = (CW < COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  logic signed [KEY_W-1:0] keys [MAX_ENTRIES];
  logic [TAG_BITS-1:0]     tags [MAX_ENTRIES];
  logic [CW-1:0]           count;

  // captured request
  logic [CMD_W-1:0]        r_cmd;
  logic signed [KEY_W-1:0] r_key;
  logic [TAG_BITS-1:0]     r_tag;
  logic [SLOT_W-1:0]       r_slot;

  logic [TAG_BITS-1:0]     tag_in;
  logic [MAX_ENTRIES-1:0]  gt;
  logic [CW-1:0]           at;
  logic                    full;
  logic                    ins_ok;
  logic                    do_insert;
  logic                    do_clear;
  logic [CW-1:0]           count_next;
  logic [IW-1:0]           slot_idx;
  logic                    slot_in_range;
  rsp_t                    rsp_next;

  always_comb begin
    tag_in         = '0;
    tag_in[TC-1:0] = req.tag_value[TC-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_cmd  <= req.command;
      r_key  <= req.key_value;
      r_tag  <= tag_in;
      r_slot <= req.slot_index;
    end
  end

  // every live cell compares against the new key at once
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      gt[i] = (r_key > keys[i]) && (CW'(i) < count);
    end
  end

  // first slot whose key is below the new one, else the end of the list
  always_comb begin
    at = (count == MAX_CNT) ? MAX_CNT : count;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (gt[i]) at = CW'(i);
    end
  end

  assign full      = (count == MAX_CNT);
  assign ins_ok    = !full || gt[MAX_ENTRIES-1];
  assign do_insert = cmd.execute && (r_cmd == CMD_INSERT) && ins_ok;
  assign do_clear  = cmd.execute && (r_cmd == CMD_CLEAR);

  always_comb begin
    count_next = count;
    if (do_clear) count_next = '0;
    else if (do_insert && !full) count_next = count + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      always_ff @(posedge clk) begin
        if (rst || do_clear) begin
          keys[g] <= '0;
          tags[g] <= '0;
        end else if (do_insert) begin
          if (CW'(g) == at) begin
            keys[g] <= r_key;
            tags[g] <= r_tag;
          end else if (g > 0) begin
            // lower entries move down one slot, the last falls off when full
            if ((CW'(g) > at) && (CW'(g) <= count)) begin
              keys[g] <= keys[(g > 0) ? g - 1 : 0];
              tags[g] <= tags[(g > 0) ? g - 1 : 0];
            end
          end
        end
      end
    end
  endgenerate

  assign slot_in_range = ({1'b0, r_slot} < (SLOT_W + 1)'(
                          (MAX_ENTRIES > 16) ? 16 : MAX_ENTRIES));

  always_comb begin
    slot_idx         = '0;
    slot_idx[SC-1:0] = r_slot[SC-1:0];
  end

  always_comb begin
    rsp_next                      = '0;
    rsp_next.entry_count[NC-1:0]  = count_next[NC-1:0];
    case (r_cmd)
      CMD_INSERT: begin
        if (ins_ok) begin
          rsp_next.accepted         = 1'b1;
          rsp_next.position[PC-1:0] = at[PC-1:0];
        end
      end
      CMD_READ: begin
        if (slot_in_range) begin
          rsp_next.read_key          = keys[slot_idx];
          rsp_next.read_tag[TC-1:0]  = tags[slot_idx][TC-1:0];
        end
      end
      CMD_CLEAR: ;
      CMD_NOP:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) rsp <= rsp_next;
  end

endmodule
